### hw/rtl/iqbmm_pkg.sv
// Shared widths, control types and state codes of the I/Q block mean magnitude unit.
package iqbmm_pkg;

	localparam int SAMPLE_WIDTH    = 16;
	localparam int FRACTION_BITS   = 8;
	localparam int COUNT_WIDTH     = 23;
	localparam int SPB_WIDTH       = 23;
	localparam int SUM_WIDTH       = 46;
	localparam int BLOCK_NUM_WIDTH = 32;

	localparam int MEAN_WIDTH = SAMPLE_WIDTH + FRACTION_BITS;
	localparam int ROOT_STEPS = MEAN_WIDTH;
	localparam int RAD_WIDTH  = 2 * ROOT_STEPS;
	localparam int SQ_WIDTH   = 2 * SAMPLE_WIDTH;
	localparam int REM_WIDTH  = ROOT_STEPS + 2;
	localparam int STEP_WIDTH = $clog2(SUM_WIDTH);

	localparam logic [SPB_WIDTH-1:0]   SPB_RESET = SPB_WIDTH'(1048576);
	localparam logic [COUNT_WIDTH-1:0] MAX_BLOCK = COUNT_WIDTH'(1) << (COUNT_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_ACCUM,
		ST_DIVIDE,
		ST_EMIT
	} iqbmm_state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic root_step;
		logic accumulate;
		logic div_step;
		logic out_load;
	} iqbmm_cmd_t;

	typedef struct packed {
		logic root_last;
		logic div_last;
		logic block_hit;
		logic out_free;
	} iqbmm_status_t;

endpackage

### hw/rtl/iqbmm_if.sv
// Handshake channel interfaces for samples, block means and the block size register.
interface iqbmm_sample_if import iqbmm_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] in_phase_sample;
	logic signed [SAMPLE_WIDTH-1:0] quadrature_sample;

	modport source (output valid, output in_phase_sample, output quadrature_sample, input ready);
	modport sink (input valid, input in_phase_sample, input quadrature_sample, output ready);
endinterface

interface iqbmm_mean_if import iqbmm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [BLOCK_NUM_WIDTH-1:0] block_number;
	logic [MEAN_WIDTH-1:0]      mean_amplitude;

	modport source (output valid, output block_number, output mean_amplitude, input ready);
	modport sink (input valid, input block_number, input mean_amplitude, output ready);
endinterface

interface iqbmm_cfg_if import iqbmm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SPB_WIDTH-1:0] block_size;

	modport source (output valid, output block_size, input ready);
	modport sink (input valid, input block_size, output ready);
endinterface

### hw/rtl/iq_block_mean_magnitude.sv
// Top level of the I/Q block mean magnitude unit: channels, controller and datapath.
// Each sample pair is squared, run through the one-bit-per-cycle square root and accumulated
// before the next ready beat. A sample that completes a block then adds a restoring division
// and an emit step that waits until the output register is free.
// A finished mean waits in the output register while the next sample pair is taken.
// Reset (arst_n low) clears the count, sum and block index and sets the block size to 2^20.
module iq_block_mean_magnitude import iqbmm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	iqbmm_sample_if.sink        samples,
	iqbmm_mean_if.source        means,
	iqbmm_cfg_if.sink           cfg
);

	iqbmm_cmd_t    cmd;
	iqbmm_status_t status;
	logic          in_ready;

	// Writes land at any beat, unchecked; software must write the block size only when idle.
	assign cfg.ready     = 1'b1;
	assign samples.ready = in_ready;

	// The controller steps each sample through squaring, the root and accumulation,
	// and on the last sample of a block through the division and the result hand-over.
	iqbmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds every arithmetic register, the block size and the result register.
	iqbmm_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_phase_sample   (samples.in_phase_sample),
		.quadrature_sample (samples.quadrature_sample),
		.cfg_valid         (cfg.valid),
		.block_size        (cfg.block_size),
		.out_valid         (means.valid),
		.out_ready         (means.ready),
		.block_number      (means.block_number),
		.mean_amplitude    (means.mean_amplitude)
	);

endmodule

### hw/rtl/iqbmm_ctrl.sv
// Sequencing state machine of the block mean magnitude unit.
module iqbmm_ctrl import iqbmm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  iqbmm_status_t status,
	output iqbmm_cmd_t    cmd
);

	iqbmm_state_t state_q;
	iqbmm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accumulate = 1'b1;
				state_d        = status.block_hit ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/iqbmm_datapath.sv
// Datapath: magnitude square root, block accumulation, mean division and result register.
module iqbmm_datapath import iqbmm_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iqbmm_cmd_t                     cmd,
	output iqbmm_status_t                  status,
	input  logic signed [SAMPLE_WIDTH-1:0] in_phase_sample,
	input  logic signed [SAMPLE_WIDTH-1:0] quadrature_sample,
	input  logic                           cfg_valid,
	input  logic [SPB_WIDTH-1:0]           block_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [BLOCK_NUM_WIDTH-1:0]     block_number,
	output logic [MEAN_WIDTH-1:0]          mean_amplitude
);

	function automatic logic [SAMPLE_WIDTH-1:0] magnitude_of(input logic [SAMPLE_WIDTH-1:0] s);
		magnitude_of = s[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~s + 1'b1) : s;
	endfunction

	logic [SPB_WIDTH-1:0]       spb_q;
	logic [SAMPLE_WIDTH-1:0]    a_q;
	logic [SAMPLE_WIDTH-1:0]    b_q;
	logic [RAD_WIDTH-1:0]       rad_q;
	logic [REM_WIDTH-1:0]       rem_q;
	logic [ROOT_STEPS-1:0]      root_q;
	logic [STEP_WIDTH-1:0]      step_q;
	logic [COUNT_WIDTH-1:0]     count_q;
	logic [SUM_WIDTH-1:0]       sum_q;
	logic [SUM_WIDTH-1:0]       quo_q;
	logic [COUNT_WIDTH-1:0]     drem_q;
	logic [COUNT_WIDTH-1:0]     divisor_q;
	logic [BLOCK_NUM_WIDTH-1:0] block_q;
	logic                       out_valid_q;
	logic [BLOCK_NUM_WIDTH-1:0] number_q;
	logic [MEAN_WIDTH-1:0]      mean_q;

	logic [SQ_WIDTH-1:0]    sq;
	logic [REM_WIDTH-1:0]   rem_sh;
	logic [REM_WIDTH-1:0]   trial;
	logic                   root_ge;
	logic [COUNT_WIDTH:0]   div_sh;
	logic [COUNT_WIDTH:0]   div_diff;
	logic                   div_ge;
	logic [COUNT_WIDTH-1:0] eff;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [SUM_WIDTH-1:0]   sum_next;

	assign sq = SQ_WIDTH'(a_q) * SQ_WIDTH'(a_q) + SQ_WIDTH'(b_q) * SQ_WIDTH'(b_q);

	// One result bit per step: bring down two radicand bits, try 4*root+1.
	assign rem_sh  = {rem_q[REM_WIDTH-3:0], rad_q[RAD_WIDTH-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign root_ge = rem_sh >= trial;

	// Restoring division, one quotient bit per step.
	assign div_sh   = {drem_q, quo_q[SUM_WIDTH-1]};
	assign div_diff = div_sh - {1'b0, divisor_q};
	assign div_ge   = div_sh >= {1'b0, divisor_q};

	// A block size of zero acts as one; sizes above MAX_BLOCK (2^22) saturate to it.
	always_comb begin
		if (spb_q == '0) begin
			eff = COUNT_WIDTH'(1);
		end else if (64'(spb_q) > 64'(MAX_BLOCK)) begin
			eff = MAX_BLOCK;
		end else begin
			eff = COUNT_WIDTH'(spb_q);
		end
	end

	assign count_next = count_q + 1'b1;
	assign sum_next   = sum_q + SUM_WIDTH'(root_q);

	assign status.root_last = step_q == STEP_WIDTH'(ROOT_STEPS - 1);
	assign status.div_last  = step_q == STEP_WIDTH'(SUM_WIDTH - 1);
	assign status.block_hit = count_next >= eff;
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q       <= SPB_RESET;
			step_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			block_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				spb_q <= block_size;
			end
			if (cmd.square || cmd.accumulate) begin
				step_q <= '0;
			end else if (cmd.root_step || cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.accumulate) begin
				if (status.block_hit) begin
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					count_q <= count_next;
					sum_q   <= sum_next;
				end
			end
			if (cmd.out_load) begin
				block_q     <= block_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= magnitude_of(in_phase_sample);
			b_q <= magnitude_of(quadrature_sample);
		end
		if (cmd.square) begin
			rad_q  <= RAD_WIDTH'(sq) << (2 * FRACTION_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= root_ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_STEPS-2:0], root_ge};
		end
		if (cmd.accumulate && status.block_hit) begin
			quo_q     <= sum_next;
			drem_q    <= '0;
			divisor_q <= count_next;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[SUM_WIDTH-2:0], div_ge};
			drem_q <= div_ge ? div_diff[COUNT_WIDTH-1:0] : div_sh[COUNT_WIDTH-1:0];
		end
		if (cmd.out_load) begin
			number_q <= block_q;
			mean_q   <= quo_q[MEAN_WIDTH-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign block_number   = number_q;
	assign mean_amplitude = mean_q;

`ifndef SYNTHESIS
	a_count_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < MAX_BLOCK)
		else $error("sample count reached the block size limit");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (divisor_q != '0 && drem_q < divisor_q))
		else $error("division remainder out of range");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_block_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> block_q == $past(block_q) + 1'b1)
		else $error("block index did not advance on a result");
`endif

endmodule
